// ----- rtl/core/packet_frame_reassembly_pool_macros.svh -----
// assertion macros for the reassembly pool checker
// needs clk and arst_n in the scope where a macro is used
`ifndef PACKET_FRAME_REASSEMBLY_POOL_MACROS_SVH
`define PACKET_FRAME_REASSEMBLY_POOL_MACROS_SVH

// same-cycle implication, off during reset
`define PFRP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfrp assertion failed");

// next-cycle implication, off during reset
`define PFRP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfrp assertion failed");

`endif

// ----- rtl/core/pfrp_pkg.sv -----
// shared types and constants of the packet reassembly slot pool
// no dependencies
package pfrp_pkg;

	localparam int POOL_SLOTS_DEF = 8;
	localparam int MAX_PACKETS    = 64;
	// wide enough for the largest pool of 64 slots
	localparam int SLOT_IDX_W     = 6;

	typedef logic [SLOT_IDX_W-1:0] slot_idx_t;
	typedef logic [6:0]            count_t;

	localparam count_t COUNT_MAX = 7'd127;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_COMPLETE = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	typedef struct packed {
		logic [15:0] frame_uid;
		logic [5:0]  packet_index;
		logic        last_flag;
	} hdr_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] slot;
		logic [5:0] store_index;
	} rsp_t;

	// search record that walks down the cell chain
	typedef struct packed {
		logic      valid;
		logic      found;
		slot_idx_t found_slot;
		count_t    found_cnt;
		logic      found_lk;
		logic [5:0] found_lidx;
		logic      has_free;
		slot_idx_t free_slot;
	} scan_t;

	// slot update broadcast to all cells
	typedef struct packed {
		logic        en;
		slot_idx_t   slot;
		logic        busy;
		logic [15:0] uid;
		count_t      cnt;
		logic        lk;
		logic [5:0]  lidx;
	} wr_t;

endpackage

// ----- rtl/core/packet_frame_reassembly_pool.sv -----
// Packet reassembly slot pool. One header beat is taken, then a search record
// walks the row of POOL_SLOTS slot cells, one cell per cycle, finding the
// busy slot with the same frame id or else the highest free slot. The search
// record passes the registered cells in turn; the result then goes to a
// pending register and from there to the response register. A new header is
// taken as soon as the previous response is in the output register, even
// while that response is still stalled.
// Slots come out of reset free; no clearing pass is needed.
// depends on pfrp_pkg and pfrp_cell
module packet_frame_reassembly_pool #(
	parameter int POOL_SLOTS = pfrp_pkg::POOL_SLOTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           hdr_valid,
	output logic           hdr_stall,
	input  pfrp_pkg::hdr_t hdr,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output pfrp_pkg::rsp_t rsp
);
	import pfrp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_HOLD = 3'b100
	} state_t;

	state_t     state_q;
	hdr_t       hdr_q;
	logic       start_q;
	scan_t      chain [POOL_SLOTS+1];
	scan_t      rec_end;
	wr_t        wr;
	rsp_t       pend_q;
	rsp_t       rsp_q;
	logic       rsp_valid_q;
	logic       accept;
	logic       finish;
	logic       load_rsp;
	logic       drop;
	slot_idx_t  sel;
	count_t     base_cnt;
	count_t     new_cnt;
	logic       new_lk;
	logic [5:0] new_lidx;
	logic       done;
	rsp_t       res;

	assign hdr_stall = (state_q != S_IDLE);
	assign accept    = hdr_valid && !hdr_stall;
	assign rec_end   = chain[POOL_SLOTS];
	assign finish    = (state_q == S_SCAN) && rec_end.valid;
	assign load_rsp  = (state_q == S_HOLD) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		chain[0]       = '0;
		chain[0].valid = start_q;
	end

	for (genvar i = 0; i < POOL_SLOTS; i++) begin : g_cell
		pfrp_cell #(
			.CELL_ID(SLOT_IDX_W'(i))
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.uid    (hdr_q.frame_uid),
			.rec_in (chain[i]),
			.wr     (wr),
			.rec_out(chain[i+1])
		);
	end

	// decision once the record leaves the last cell
	always_comb begin
		drop     = (32'(hdr_q.packet_index) >= MAX_PACKETS) ||
			(!rec_end.found && !rec_end.has_free);
		sel      = rec_end.found ? rec_end.found_slot : rec_end.free_slot;
		base_cnt = rec_end.found ? rec_end.found_cnt : '0;
		new_lk   = rec_end.found ? rec_end.found_lk : 1'b0;
		new_lidx = rec_end.found ? rec_end.found_lidx : '0;
		if (hdr_q.last_flag) begin
			new_lk   = 1'b1;
			new_lidx = hdr_q.packet_index;
		end
		new_cnt = (base_cnt == COUNT_MAX) ? COUNT_MAX : base_cnt + 7'd1;
		done    = new_lk && (new_cnt == ({1'b0, new_lidx} + 7'd1));

		wr.en   = finish && !drop;
		wr.slot = sel;
		wr.busy = !done;
		wr.uid  = hdr_q.frame_uid;
		wr.cnt  = new_cnt;
		wr.lk   = new_lk;
		wr.lidx = new_lidx;

		res.store_index = hdr_q.packet_index;
		if (drop) begin
			res.status = ST_FULL;
			res.slot   = '0;
		end else begin
			res.status = done ? ST_COMPLETE : ST_INSERTED;
			res.slot   = sel[2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			start_q <= accept;
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (rec_end.valid) state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (load_rsp) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) hdr_q <= hdr;
		if (finish) pend_q <= res;
		if (load_rsp) rsp_q <= pend_q;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- rtl/core/pfrp_cell.sv -----
// one slot of the reassembly pool: holds the slot state and passes the
// search record on to the next cell; depends on pfrp_pkg
module pfrp_cell #(
	parameter pfrp_pkg::slot_idx_t CELL_ID = '0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [15:0]     uid,
	input  pfrp_pkg::scan_t rec_in,
	input  pfrp_pkg::wr_t   wr,
	output pfrp_pkg::scan_t rec_out
);
	import pfrp_pkg::*;

	logic        busy_q;
	logic [15:0] uid_q;
	count_t      cnt_q;
	logic        lk_q;
	logic [5:0]  lidx_q;
	scan_t       rec_d;
	scan_t       rec_q;
	logic        hit;

	assign hit = wr.en && (wr.slot == CELL_ID);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (hit) begin
			busy_q <= wr.busy;
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			uid_q  <= wr.uid;
			cnt_q  <= wr.cnt;
			lk_q   <= wr.lk;
			lidx_q <= wr.lidx;
		end
	end

	always_comb begin
		rec_d = rec_in;
		// lowest busy match wins, so keep an earlier hit
		if (busy_q && !rec_in.found && (uid_q == uid)) begin
			rec_d.found      = 1'b1;
			rec_d.found_slot = CELL_ID;
			rec_d.found_cnt  = cnt_q;
			rec_d.found_lk   = lk_q;
			rec_d.found_lidx = lidx_q;
		end
		// highest free slot wins, so later cells overwrite
		if (!busy_q) begin
			rec_d.has_free  = 1'b1;
			rec_d.free_slot = CELL_ID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else begin
			rec_q <= rec_d;
		end
	end

	assign rec_out = rec_q;

endmodule

// ----- rtl/core/pfrp_checker.sv -----
// port-level checks of the reassembly pool, bound to the top level
// depends on pfrp_pkg and the macro header
`include "packet_frame_reassembly_pool_macros.svh"

module pfrp_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           hdr_valid,
	input logic           hdr_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input pfrp_pkg::rsp_t rsp
);
	import pfrp_pkg::*;

	// a taken header keeps the block busy on the next cycle
	`PFRP_ASSERT_NEXT(a_busy_after_accept, hdr_valid && !hdr_stall, hdr_stall)

	// dropped beats name no slot
	`PFRP_ASSERT_IMP(a_full_slot_zero, rsp_valid && (rsp.status == ST_FULL), rsp.slot == 3'd0)

	// status is one of the three codes
	`PFRP_ASSERT_IMP(a_status_code, rsp_valid,
		(rsp.status == ST_INSERTED) || (rsp.status == ST_COMPLETE) || (rsp.status == ST_FULL))

	// a stalled response beat holds
	`PFRP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

endmodule

bind packet_frame_reassembly_pool pfrp_checker u_pfrp_checker (.*);
